[design/prrc_pkg.sv]
package prrc_pkg;

   // Receive frame layout
   localparam int unsigned RX_CAPACITY = 256;
   localparam int unsigned FRAME_CNT_W = $clog2(RX_CAPACITY + 1);
   localparam int unsigned TYPE_POS    = 8;
   localparam int unsigned TIME_POS    = 13;
   localparam int unsigned TIME_BYTES  = 4;

   // Timing constants
   localparam logic [31:0] TZ_OFFSET   = 32'd28800;
   localparam int unsigned DAY_SECONDS = 86400;
   localparam int unsigned MAX_RESENDS = 3;
   localparam int unsigned RETRY_W     = 2;

   // Midnight check: 86400 = 128 * 675. The low bits must be zero and the
   // upper 25 bits must be a multiple of 675, found with a reciprocal multiply.
   localparam int unsigned DAY_SHIFT   = 7;
   localparam int unsigned DAY_ODD     = DAY_SECONDS >> DAY_SHIFT;
   localparam int unsigned DAY_HI_W    = 32 - DAY_SHIFT;
   localparam int unsigned RECIP_SHIFT = 35;
   localparam longint unsigned RECIP   =
      ((64'd1 << RECIP_SHIFT) + DAY_ODD - 1) / DAY_ODD;
   localparam int unsigned RECIP_W     = 26;
   localparam int unsigned PROD_W      = DAY_HI_W + RECIP_W;
   localparam int unsigned QUOT_W      = 16;

   // Queue between the front and the back
   localparam int unsigned ITEM_QUEUE_DEPTH = 4;
   localparam int unsigned ITEM_PTR_W       = $clog2(ITEM_QUEUE_DEPTH);
   localparam int unsigned ITEM_CNT_W       = $clog2(ITEM_QUEUE_DEPTH + 1);

   // Register map
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_IDX_W  = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SEND_PERIOD      = 3'd0,
      REG_REPLY_WAIT_TICKS = 3'd1,
      REG_SYNC_ENABLE      = 3'd2,
      REG_TYPE_SYNC_INIT   = 3'd3,
      REG_TYPE_SYNC_RUN    = 3'd4,
      REG_TYPE_FLOW        = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      KIND_BYTE    = 2'd0,
      KIND_TIMEOUT = 2'd1,
      KIND_TICK    = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      TX_NONE   = 2'd0,
      TX_NEW    = 2'd1,
      TX_RESEND = 2'd2
   } tx_type;

   typedef enum logic [1:0] {
      ST_NONE     = 2'd0,
      ST_ACCEPTED = 2'd1,
      ST_REJECTED = 2'd2,
      ST_GAVE_UP  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SYNC_NONE    = 2'd0,
      SYNC_POWERUP = 2'd1,
      SYNC_RUNNING = 2'd2
   } sync_type;

   typedef struct packed {
      logic [15:0] send_period;
      logic [15:0] reply_wait_ticks;
      logic        sync_enable;
      logic [7:0]  type_sync_init;
      logic [7:0]  type_sync_run;
      logic [7:0]  type_flow;
   } cfg_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] rx_byte;
      logic       midnight;
   } item_type;

   typedef struct packed {
      logic [1:0]  tx_action;
      logic        rtc_write;
      logic [31:0] rtc_value;
      logic [1:0]  reply_status;
      logic [1:0]  sync_mode;
   } result_type;

endpackage

[design/prrc_item_queue.sv]
module prrc_item_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  prrc_pkg::item_type wr_item,
   output logic               q_full,
   input  logic               rd_en,
   output logic               q_valid,
   output prrc_pkg::item_type rd_item
);

   prrc_pkg::item_type                  store_ff [prrc_pkg::ITEM_QUEUE_DEPTH];
   logic [prrc_pkg::ITEM_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [prrc_pkg::ITEM_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [prrc_pkg::ITEM_CNT_W-1:0]     count_ff, count_in;
   logic                                do_wr, do_rd;

   assign q_full  = (count_ff == prrc_pkg::ITEM_CNT_W'(prrc_pkg::ITEM_QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign rd_item = store_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && q_valid;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         store_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

[design/prrc_front.sv]
module prrc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [1:0]         req_kind,
   input  logic [7:0]         req_rx_byte,
   input  logic [31:0]        req_rtc_now,
   input  logic               item_pop,
   output logic               item_valid,
   output prrc_pkg::item_type item
);

   // Stage A: captured input, split for the midnight check.
   logic                             a_valid_ff, a_valid_in;
   logic [1:0]                       a_kind_ff;
   logic [7:0]                       a_byte_ff;
   logic [prrc_pkg::DAY_HI_W-1:0]    a_hi_ff;
   logic                             a_low_zero_ff;

   // Stage B: quotient of the upper bits by the odd part of a day.
   logic                             b_valid_ff, b_valid_in;
   logic [1:0]                       b_kind_ff;
   logic [7:0]                       b_byte_ff;
   logic [prrc_pkg::DAY_HI_W-1:0]    b_hi_ff;
   logic                             b_low_zero_ff;
   logic [prrc_pkg::QUOT_W-1:0]      b_quot_ff;

   logic [prrc_pkg::PROD_W-1:0]      a_prod;
   logic [prrc_pkg::DAY_HI_W-1:0]    b_back;
   logic                             a_ready, b_ready, q_full, accept;
   prrc_pkg::item_type               b_item;

   assign b_ready = !b_valid_ff || !q_full;
   assign a_ready = !a_valid_ff || b_ready;
   assign full    = !a_ready;
   assign accept  = push && a_ready;

   assign a_prod = prrc_pkg::PROD_W'(a_hi_ff) *
                   prrc_pkg::PROD_W'(prrc_pkg::RECIP_W'(prrc_pkg::RECIP));
   assign b_back = prrc_pkg::DAY_HI_W'(b_quot_ff) *
                   prrc_pkg::DAY_HI_W'(prrc_pkg::DAY_ODD);

   always_comb begin
      b_item.kind     = b_kind_ff;
      b_item.rx_byte  = b_byte_ff;
      b_item.midnight = b_low_zero_ff && (b_back == b_hi_ff);
   end

   always_comb begin
      a_valid_in = a_valid_ff;
      if (a_ready) begin
         a_valid_in = push;
      end
      b_valid_in = b_valid_ff;
      if (b_ready) begin
         b_valid_in = a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_kind_ff     <= req_kind;
         a_byte_ff     <= req_rx_byte;
         a_hi_ff       <= req_rtc_now[31:prrc_pkg::DAY_SHIFT];
         a_low_zero_ff <= (req_rtc_now[prrc_pkg::DAY_SHIFT-1:0] == '0);
      end
      if (b_ready && a_valid_ff) begin
         b_kind_ff     <= a_kind_ff;
         b_byte_ff     <= a_byte_ff;
         b_hi_ff       <= a_hi_ff;
         b_low_zero_ff <= a_low_zero_ff;
         b_quot_ff     <= a_prod[prrc_pkg::RECIP_SHIFT +: prrc_pkg::QUOT_W];
      end
   end

   prrc_item_queue u_item_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (b_valid_ff),
      .wr_item (b_item),
      .q_full  (q_full),
      .rd_en   (item_pop),
      .q_valid (item_valid),
      .rd_item (item)
   );

endmodule

[design/prrc_back.sv]
module prrc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  prrc_pkg::cfg_type    cfg,
   input  logic                 item_valid,
   input  prrc_pkg::item_type   item,
   output logic                 item_pop,
   input  logic                 pop,
   output logic                 empty,
   output prrc_pkg::result_type result
);

   logic [prrc_pkg::FRAME_CNT_W-1:0] frame_count_ff, frame_count_in;
   logic                             frame_done_ff, frame_done_in;
   logic [7:0]                       reply_type_ff, reply_type_in;
   logic [7:0]                       time_bytes_ff [prrc_pkg::TIME_BYTES];
   logic [7:0]                       time_bytes_in [prrc_pkg::TIME_BYTES];
   logic [15:0]                      period_count_ff, period_count_in;
   logic                             awaiting_ff, awaiting_in;
   logic [15:0]                      wait_count_ff, wait_count_in;
   logic [prrc_pkg::RETRY_W-1:0]     retry_count_ff, retry_count_in;
   prrc_pkg::sync_type               sync_state_ff, sync_state_in;

   // Two-entry result queue
   prrc_pkg::result_type             res_ff [2];
   logic                             res_wr_ptr_ff, res_rd_ptr_ff;
   logic [1:0]                       res_count_ff, res_count_in;
   logic                             res_full, fire, do_pop;
   prrc_pkg::result_type             res_in;

   logic [prrc_pkg::FRAME_CNT_W-1:0] time_off;
   logic [31:0]                      reply_seconds;
   logic                             is_sync;

   assign res_full = (res_count_ff == 2'd2);
   assign empty    = (res_count_ff == 2'd0);
   assign fire     = item_valid && !res_full;
   assign item_pop = fire;
   assign do_pop   = pop && !empty;
   assign result   = res_ff[res_rd_ptr_ff];

   assign time_off      = frame_count_ff - prrc_pkg::FRAME_CNT_W'(prrc_pkg::TIME_POS);
   assign reply_seconds = {time_bytes_ff[0], time_bytes_ff[1],
                           time_bytes_ff[2], time_bytes_ff[3]} + prrc_pkg::TZ_OFFSET;
   assign is_sync       = (reply_type_ff == cfg.type_sync_run) ||
                          (reply_type_ff == cfg.type_sync_init);

   always_comb begin
      frame_count_in  = frame_count_ff;
      frame_done_in   = frame_done_ff;
      reply_type_in   = reply_type_ff;
      time_bytes_in   = time_bytes_ff;
      period_count_in = period_count_ff;
      awaiting_in     = awaiting_ff;
      wait_count_in   = wait_count_ff;
      retry_count_in  = retry_count_ff;
      sync_state_in   = sync_state_ff;
      res_in          = '0;

      case (prrc_pkg::kind_type'(item.kind))
         prrc_pkg::KIND_BYTE: begin
            if (!frame_done_ff) begin
               if (frame_count_ff < prrc_pkg::FRAME_CNT_W'(prrc_pkg::RX_CAPACITY)) begin
                  if (frame_count_ff == prrc_pkg::FRAME_CNT_W'(prrc_pkg::TYPE_POS)) begin
                     reply_type_in = item.rx_byte;
                  end else if (frame_count_ff >=
                                  prrc_pkg::FRAME_CNT_W'(prrc_pkg::TIME_POS) &&
                               time_off <
                                  prrc_pkg::FRAME_CNT_W'(prrc_pkg::TIME_BYTES)) begin
                     time_bytes_in[time_off[1:0]] = item.rx_byte;
                  end
                  frame_count_in = frame_count_ff + 1'b1;
               end else begin
                  frame_done_in = 1'b1;
               end
            end
         end
         prrc_pkg::KIND_TIMEOUT: begin
            if (frame_count_ff != '0) begin
               frame_done_in = 1'b1;
            end
         end
         prrc_pkg::KIND_TICK: begin
            period_count_in = period_count_ff + 1'b1;
            if (period_count_in >= cfg.send_period && !awaiting_ff) begin
               period_count_in  = '0;
               frame_count_in   = '0;
               frame_done_in    = 1'b0;
               res_in.tx_action = prrc_pkg::TX_NEW;
               awaiting_in      = 1'b1;
            end
            if (awaiting_in) begin
               wait_count_in = wait_count_ff + 1'b1;
            end
            if (wait_count_in >= cfg.reply_wait_ticks) begin
               wait_count_in = '0;
               if (frame_done_in) begin
                  if (is_sync) begin
                     res_in.rtc_value = reply_seconds;
                     res_in.rtc_write = 1'b1;
                     sync_state_in    = prrc_pkg::SYNC_NONE;
                  end
                  if (is_sync || reply_type_ff == cfg.type_flow) begin
                     retry_count_in      = '0;
                     awaiting_in         = 1'b0;
                     res_in.reply_status = prrc_pkg::ST_ACCEPTED;
                  end else begin
                     frame_count_in      = '0;
                     frame_done_in       = 1'b0;
                     res_in.reply_status = prrc_pkg::ST_REJECTED;
                  end
               end else begin
                  res_in.tx_action = prrc_pkg::TX_RESEND;
                  retry_count_in   = retry_count_ff + 1'b1;
                  if (retry_count_in >= prrc_pkg::RETRY_W'(prrc_pkg::MAX_RESENDS)) begin
                     retry_count_in      = '0;
                     awaiting_in         = 1'b0;
                     res_in.reply_status = prrc_pkg::ST_GAVE_UP;
                  end
               end
            end
            if (cfg.sync_enable && item.midnight) begin
               sync_state_in = prrc_pkg::SYNC_RUNNING;
            end
         end
         default: begin
         end
      endcase
      res_in.sync_mode = sync_state_in;
   end

   always_comb begin
      res_count_in = res_count_ff;
      if (fire && !do_pop) begin
         res_count_in = res_count_ff + 1'b1;
      end else if (do_pop && !fire) begin
         res_count_in = res_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff  <= '0;
         frame_done_ff   <= 1'b0;
         reply_type_ff   <= '0;
         time_bytes_ff   <= '{default: '0};
         period_count_ff <= '0;
         awaiting_ff     <= 1'b0;
         wait_count_ff   <= '0;
         retry_count_ff  <= '0;
         sync_state_ff   <= prrc_pkg::SYNC_POWERUP;
         res_wr_ptr_ff   <= 1'b0;
         res_rd_ptr_ff   <= 1'b0;
         res_count_ff    <= '0;
      end else begin
         if (fire) begin
            frame_count_ff  <= frame_count_in;
            frame_done_ff   <= frame_done_in;
            reply_type_ff   <= reply_type_in;
            time_bytes_ff   <= time_bytes_in;
            period_count_ff <= period_count_in;
            awaiting_ff     <= awaiting_in;
            wait_count_ff   <= wait_count_in;
            retry_count_ff  <= retry_count_in;
            sync_state_ff   <= sync_state_in;
            res_wr_ptr_ff   <= !res_wr_ptr_ff;
         end
         if (do_pop) begin
            res_rd_ptr_ff <= !res_rd_ptr_ff;
         end
         res_count_ff <= res_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         res_ff[res_wr_ptr_ff] <= res_in;
      end
   end

endmodule

[design/periodic_report_retry_controller.sv]
// Periodic report and retry controller. Each transfer on the request queue
// is a received byte, a receive idle timeout or a tick, and every request
// produces exactly one transfer on the response queue, in order. Responses
// tell the transmitter to send a new report or resend the last one, tell the
// clock to load a new value from a time-sync reply, and report the reply
// outcome and the pending sync request. The block sustains one request per
// clock cycle while the response side keeps up: a two-stage front end captures
// the request and works out the midnight check (a reciprocal multiply by the
// odd factor of a day, then a multiply-back compare), a four-entry queue
// decouples it from the back end, and the back end updates the frame and
// retry state and writes a two-entry response queue. A request is held in
// stage A, stage B, the four-entry queue and the response queue in turn;
// full rises only when both queues have filled behind a stalled response side.
module periodic_report_retry_controller (
   input  logic        clock,
   input  logic        reset,

   // Request queue
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_rx_byte,
   input  logic [31:0] req_rtc_now,

   // Response queue
   input  logic        pop,
   output logic        empty,
   output logic [1:0]  rsp_tx_action,
   output logic        rsp_rtc_write,
   output logic [31:0] rsp_rtc_value,
   output logic [1:0]  rsp_reply_status,
   output logic [1:0]  rsp_sync_mode,

   // Register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [prrc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   prrc_pkg::cfg_type    cfg_ff, cfg_in;
   prrc_pkg::item_type   item;
   prrc_pkg::result_type result;
   logic                 item_valid, item_pop, csr_write;
   prrc_pkg::reg_index_type csr_index;

   // Registers sit on 32-bit words; the word index selects the register.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = prrc_pkg::reg_index_type'(paddr[prrc_pkg::CSR_ADDR_W-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            prrc_pkg::REG_SEND_PERIOD:      cfg_in.send_period      = pwdata[15:0];
            prrc_pkg::REG_REPLY_WAIT_TICKS: cfg_in.reply_wait_ticks = pwdata[15:0];
            prrc_pkg::REG_SYNC_ENABLE:      cfg_in.sync_enable      = pwdata[0];
            prrc_pkg::REG_TYPE_SYNC_INIT:   cfg_in.type_sync_init   = pwdata[7:0];
            prrc_pkg::REG_TYPE_SYNC_RUN:    cfg_in.type_sync_run    = pwdata[7:0];
            prrc_pkg::REG_TYPE_FLOW:        cfg_in.type_flow        = pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // Reads return the register value, zero-extended; unused words read zero.
   always_comb begin
      unique case (csr_index)
         prrc_pkg::REG_SEND_PERIOD:      prdata = {16'd0, cfg_ff.send_period};
         prrc_pkg::REG_REPLY_WAIT_TICKS: prdata = {16'd0, cfg_ff.reply_wait_ticks};
         prrc_pkg::REG_SYNC_ENABLE:      prdata = {31'd0, cfg_ff.sync_enable};
         prrc_pkg::REG_TYPE_SYNC_INIT:   prdata = {24'd0, cfg_ff.type_sync_init};
         prrc_pkg::REG_TYPE_SYNC_RUN:    prdata = {24'd0, cfg_ff.type_sync_run};
         prrc_pkg::REG_TYPE_FLOW:        prdata = {24'd0, cfg_ff.type_flow};
         default:                        prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.send_period      <= 16'd10;
         cfg_ff.reply_wait_ticks <= 16'd100;
         cfg_ff.sync_enable      <= 1'b1;
         cfg_ff.type_sync_init   <= 8'd128;
         cfg_ff.type_sync_run    <= 8'd129;
         cfg_ff.type_flow        <= 8'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end takes requests and classifies ticks that fall on midnight.
   prrc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_kind    (req_kind),
      .req_rx_byte (req_rx_byte),
      .req_rtc_now (req_rtc_now),
      .item_pop    (item_pop),
      .item_valid  (item_valid),
      .item        (item)
   );

   // The back end holds the frame, send and retry state and queues responses.
   prrc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .pop        (pop),
      .empty      (empty),
      .result     (result)
   );

   assign rsp_tx_action    = result.tx_action;
   assign rsp_rtc_write    = result.rtc_write;
   assign rsp_rtc_value    = result.rtc_value;
   assign rsp_reply_status = result.reply_status;
   assign rsp_sync_mode    = result.sync_mode;

`ifndef SYNTHESIS
   // A clock load always clears the power-up sync request.
   a_write_clears_powerup: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_rtc_write) |-> (rsp_sync_mode != prrc_pkg::SYNC_POWERUP))
      else $error("clock load left power-up sync pending");

   // The clock value is only meaningful when a load is requested.
   a_value_needs_write: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_rtc_write) |-> (rsp_rtc_value == 32'd0))
      else $error("clock value without clock load");

   // A fresh send clears the frame, so the same response cannot judge a reply.
   a_new_send_no_status: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_tx_action == prrc_pkg::TX_NEW) |->
         (rsp_reply_status == prrc_pkg::ST_NONE))
      else $error("new send reported together with a reply outcome");

   // The back end only takes a request that the front end offers.
   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> item_valid)
      else $error("back end took a request from an empty queue");
`endif

endmodule
